FILE: sv/tksk_pkg.sv
// ---------------------------------------------------------------------------
// Top-k score keeper package
// Shared types and constants for the sorted cell chain and its controller.
// ---------------------------------------------------------------------------
package tksk_pkg;

   // Item actions carried in req_tuser
   localparam logic [1:0] ACT_PUSH    = 2'd0;
   localparam logic [1:0] ACT_QUERY   = 2'd1;
   localparam logic [1:0] ACT_EXTRACT = 2'd2;

   // Fixed field widths
   localparam int unsigned ID_W    = 32;
   localparam int unsigned SCORE_W = 32;
   localparam int unsigned NODE_W  = 20;
   localparam int unsigned COUNT_W = 5;

   // Reported worst score while nothing is held
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   // Default k after reset
   localparam logic [COUNT_W-1:0] KEEP_RESET = 5'd10;

   // One held entry
   typedef struct packed {
      logic [ID_W-1:0]           id;
      logic signed [SCORE_W-1:0] score;
      logic [NODE_W-1:0]         index;
   } entry_type;

   // Chain-wide control, broadcast to every cell
   typedef struct packed {
      logic push;   // insert the broadcast entry, shifting lower entries down
      logic pop;    // shift every entry one place towards the head
   } ctl_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RESP  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

endpackage

FILE: sv/tksk_cell.sv
// ---------------------------------------------------------------------------
// Top-k score keeper cell
// One slot of the sorted list. Compares the broadcast entry against its own
// and takes the new entry, its upper neighbour's entry or its lower
// neighbour's entry.
// ---------------------------------------------------------------------------
module tksk_cell (
   input  logic                clock,
   input  tksk_pkg::ctl_type   ctl,
   input  tksk_pkg::entry_type new_entry,
   input  logic                valid,         // slot is below the fill level
   input  logic                upper_ahead,   // new entry goes above the upper cell
   input  tksk_pkg::entry_type upper_entry,
   input  tksk_pkg::entry_type lower_entry,
   output logic                ahead,         // new entry goes above this cell
   output tksk_pkg::entry_type entry
);
   import tksk_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Strictly greater goes above, so equal scores keep arrival order
   assign ahead = !valid || (new_entry.score > entry_ff.score);

   // Slot update
   always_comb begin
      entry_in = entry_ff;
      priority if (ctl.pop) begin
         entry_in = lower_entry;
      end else if (ctl.push && upper_ahead) begin
         entry_in = upper_entry;
      end else if (ctl.push && ahead) begin
         entry_in = new_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: sv/top_k_score_keeper.sv
// ---------------------------------------------------------------------------
// Top-k score keeper
// Holds the k best (id, score, node index) entries in a sorted cell chain.
// ---------------------------------------------------------------------------
// A push, query or unused action is accepted and the chain updated at the
// accepting edge; its single result is shown from the next cycle until taken,
// after which req_tready returns. An extract of n held entries gives n
// results: the chain shifts one entry out of its head cell each time a result
// is taken, best first, with tlast on the final one; an extract while empty
// gives one status result. Only one item is in flight at a time. keep_count
// is written through csr_wr_en and csr_wr_data, and the user may only change
// it while the block is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module top_k_score_keeper #(
   parameter int unsigned MAX_KEEP   = 16,
   parameter int unsigned INDEX_BITS = 20
) (
   input  logic         clock,
   input  logic         reset,
   // configuration
   input  logic         csr_wr_en,
   input  logic [4:0]   csr_wr_data,   // keep_count
   // items in
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,     // entry_id, score, node_index, zero pad
   input  logic [1:0]   req_tuser,     // action
   // results out
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,     // accepted, worst_score, held_count,
                                       // out_id, out_score, out_index, zero pad
   output logic         rsp_tuser,     // out_valid
   output logic         rsp_tlast
);
   import tksk_pkg::*;

   localparam int unsigned FILL_W = $clog2(MAX_KEEP + 1);
   localparam int unsigned KW     = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;
   localparam int unsigned IDX_W  = (INDEX_BITS < NODE_W) ? INDEX_BITS : NODE_W;
   localparam logic [NODE_W-1:0] IDX_MASK =
      NODE_W'((33'(1) << IDX_W) - 33'(1));

   state_type          state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [COUNT_W-1:0] keep_count_ff, keep_count_in;
   logic               acc_ff, acc_in;

   logic                      req_acc, rsp_acc;
   logic [1:0]                action;
   logic signed [SCORE_W-1:0] req_score;
   entry_type                 new_entry;
   ctl_type                   cell_ctl;

   logic [KW-1:0]             fill_x, kc_x, eff_k;
   logic                      has_room, take;
   logic signed [SCORE_W-1:0] worst_or, worst;

   logic [MAX_KEEP-1:0] valid_vec, ahead_vec, upper_ahead_vec, last_vec;
   entry_type           cell_q [MAX_KEEP];
   entry_type           upper_arr [MAX_KEEP];
   entry_type           lower_arr [MAX_KEEP];

   // Handshakes and input fields
   assign req_acc   = req_tvalid && req_tready;
   assign rsp_acc   = rsp_tvalid && rsp_tready;
   assign action    = req_tuser;
   assign req_score = req_tdata[63:32];
   assign new_entry.id    = req_tdata[31:0];
   assign new_entry.score = req_score;
   assign new_entry.index = req_tdata[83:64] & IDX_MASK;

   // Effective k: zero acts as one, capped at MAX_KEEP
   assign fill_x = KW'(fill_ff);
   assign kc_x   = KW'(keep_count_ff);
   always_comb begin
      eff_k = kc_x;
      if (kc_x == '0) begin
         eff_k = KW'(1);
      end
      if (eff_k > KW'(MAX_KEEP)) begin
         eff_k = KW'(MAX_KEEP);
      end
   end

   // Cell chain wiring
   for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
      assign valid_vec[g] = FILL_W'(g) < fill_ff;
      if (g == 0) begin : g_head
         assign upper_ahead_vec[g] = 1'b0;
         assign upper_arr[g]       = new_entry;
      end else begin : g_body
         assign upper_ahead_vec[g] = ahead_vec[g-1];
         assign upper_arr[g]       = cell_q[g-1];
      end
      if (g == MAX_KEEP - 1) begin : g_tail
         assign lower_arr[g] = cell_q[g];
         assign last_vec[g]  = valid_vec[g];
      end else begin : g_mid
         assign lower_arr[g] = cell_q[g+1];
         assign last_vec[g]  = valid_vec[g] && !valid_vec[g+1];
      end

      tksk_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl),
         .new_entry   (new_entry),
         .valid       (valid_vec[g]),
         .upper_ahead (upper_ahead_vec[g]),
         .upper_entry (upper_arr[g]),
         .lower_entry (lower_arr[g]),
         .ahead       (ahead_vec[g]),
         .entry       (cell_q[g])
      );
   end

   // Worst held score: the cell at the fill boundary
   always_comb begin
      worst_or = '0;
      for (int i = 0; i < MAX_KEEP; i++) begin
         if (last_vec[i]) begin
            worst_or = worst_or | cell_q[i].score;
         end
      end
   end
   assign worst = (fill_ff == '0) ? SCORE_MIN : worst_or;

   // Would a push of this score be taken
   assign has_room = fill_x < eff_k;
   assign take     = has_room || ((fill_ff != '0) && (req_score > worst));

   // Chain control
   assign cell_ctl.push = req_acc && (action == ACT_PUSH) && take;
   assign cell_ctl.pop  = (state_ff == ST_DRAIN) && rsp_acc;

   // Controller
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      acc_in        = acc_ff;
      keep_count_in = csr_wr_en ? csr_wr_data : keep_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_RESP;
               acc_in   = 1'b0;
               priority if (action == ACT_PUSH) begin
                  acc_in = take;
                  if (take && has_room) begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end else if (action == ACT_QUERY) begin
                  acc_in = take;
               end else if (action == ACT_EXTRACT) begin
                  if (fill_ff != '0) begin
                     state_in = ST_DRAIN;
                  end
               end else begin
                  acc_in = 1'b0;
               end
            end
         end
         ST_RESP: begin
            if (rsp_acc) begin
               state_in = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (rsp_acc) begin
               fill_in = fill_ff - FILL_W'(1);
               if (fill_ff == FILL_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         keep_count_ff <= KEEP_RESET;
         acc_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         keep_count_ff <= keep_count_in;
         acc_ff        <= acc_in;
      end
   end

   // Result item
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP) || (state_ff == ST_DRAIN);
   assign rsp_tuser  = (state_ff == ST_DRAIN);
   assign rsp_tlast  = (state_ff == ST_RESP) || (fill_ff == FILL_W'(1));

   always_comb begin
      rsp_tdata = '0;
      if (state_ff == ST_DRAIN) begin
         rsp_tdata[32:1]    = SCORE_MIN;
         rsp_tdata[69:38]   = cell_q[0].id;
         rsp_tdata[101:70]  = cell_q[0].score;
         rsp_tdata[121:102] = cell_q[0].index;
      end else begin
         rsp_tdata[0]     = acc_ff;
         rsp_tdata[32:1]  = worst;
         rsp_tdata[37:33] = fill_x[COUNT_W-1:0];
      end
   end

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_KEEP))
      else $error("fill count beyond chain length");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (fill_ff != '0))
      else $error("draining an empty chain");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (action != ACT_EXTRACT)) |=> (state_ff == ST_RESP))
      else $error("non-extract item did not give a single result");

   a_push_grows_by_one: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (fill_ff <= $past(fill_ff) + FILL_W'(1)))
      else $error("fill grew by more than one entry");

endmodule

FILE: dv/score_keeper_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Top-k score keeper checker
// Watches the item, result and csr channels of the score keeper. It keeps its
// own sorted store of the best entries, works out every result each accepted
// item should give, and compares each result taken at rsp with the oldest one
// still due. Mismatches and results that nobody expected are counted.
// ---------------------------------------------------------------------------
module score_keeper_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [4:0]   csr_wr_data,   // keep_count
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [87:0]  req_tdata,     // entry_id, score, node_index, zero pad
   input  logic [1:0]   req_tuser,     // action
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,     // accepted, worst_score, held_count,
                                       // out_id, out_score, out_index, zero pad
   input  logic         rsp_tuser,     // out_valid
   input  logic         rsp_tlast,
   output int unsigned  mismatch_count,
   output int unsigned  reports_due
);
   import tksk_pkg::*;

   localparam int unsigned KEEP_MAX    = 16;
   localparam int unsigned SHOW_ERRORS = 10;

   // One result of the keeper, as seen on rsp
   typedef struct packed {
      logic                      accepted;
      logic signed [SCORE_W-1:0] floor_score;
      logic [COUNT_W-1:0]        held_count;
      logic                      out_valid;
      logic [ID_W-1:0]           out_id;
      logic signed [SCORE_W-1:0] out_score;
      logic [NODE_W-1:0]         out_index;
      logic                      last;
   } report_type;

   report_type         predicted_reports[$];
   entry_type          ranked[KEEP_MAX];   // best at slot 0
   int unsigned        ranked_fill;
   logic [COUNT_W-1:0] keep_count;
   int unsigned        mismatches = 0;

   // k as the keeper applies it: 0 acts as 1, large values saturate
   function automatic int unsigned keep_limit();
      if (keep_count == 0) return 1;
      if (keep_count > KEEP_MAX) return KEEP_MAX;
      return 32'(keep_count);
   endfunction

   function automatic logic signed [SCORE_W-1:0] lowest_held();
      if (ranked_fill == 0) return SCORE_MIN;
      return ranked[ranked_fill-1].score;
   endfunction

   // Append a result to the tail of the due list
   function automatic void queue_report(report_type r);
      predicted_reports.insert(predicted_reports.size(), r);
   endfunction

   // Status-only result reflecting the store after the step
   function automatic report_type status_report(logic acc);
      report_type r;
      r             = '0;
      r.accepted    = acc;
      r.floor_score = lowest_held();
      r.held_count  = COUNT_W'(ranked_fill);
      r.last        = 1'b1;
      return r;
   endfunction

   // Insert behind every entry of equal or better score
   function automatic void insert_ranked(entry_type e);
      int unsigned pos;
      pos = ranked_fill;
      while (pos > 0 && $signed(ranked[pos-1].score) < $signed(e.score)) begin
         ranked[pos] = ranked[pos-1];
         pos--;
      end
      ranked[pos] = e;
      ranked_fill++;
   endfunction

   // Advance the store by one item and queue the results it gives
   function automatic void apply_item(logic [1:0] action, entry_type e);
      int unsigned count;
      report_type  r;
      case (action)
         ACT_PUSH: begin
            if (ranked_fill < keep_limit()) begin
               insert_ranked(e);
               queue_report(status_report(1'b1));
            end else if (ranked_fill > 0 &&
                         $signed(e.score) > $signed(lowest_held())) begin
               // evict the newest of the lowest
               ranked_fill--;
               insert_ranked(e);
               queue_report(status_report(1'b1));
            end else begin
               queue_report(status_report(1'b0));
            end
         end
         ACT_QUERY: begin
            queue_report(status_report(
               ranked_fill < keep_limit() ||
               $signed(e.score) > $signed(lowest_held())));
         end
         ACT_EXTRACT: begin
            count       = ranked_fill;
            ranked_fill = 0;
            if (count == 0) queue_report(status_report(1'b0));
            for (int unsigned i = 0; i < count; i++) begin
               r           = status_report(1'b0);
               r.out_valid = 1'b1;
               r.out_id    = ranked[i].id;
               r.out_score = ranked[i].score;
               r.out_index = ranked[i].index;
               r.last      = (i + 1 == count);
               queue_report(r);
            end
         end
         default: begin
            // unused action: status only
            queue_report(status_report(1'b0));
         end
      endcase
   endfunction

   function automatic string report_text(report_type r);
      return $sformatf({"acc=%0b worst=%0d held=%0d valid=%0b ",
                        "id=%h score=%0d index=%h last=%0b"},
                       r.accepted, r.floor_score, r.held_count, r.out_valid,
                       r.out_id, r.out_score, r.out_index, r.last);
   endfunction

   // Results are compared before the item of the same edge is applied
   always @(posedge clock) begin
      report_type seen;
      report_type want;
      entry_type  item;
      if (reset) begin
         ranked_fill = 0;
         keep_count  = KEEP_RESET;
         predicted_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.accepted    = rsp_tdata[0];
            seen.floor_score = rsp_tdata[32:1];
            seen.held_count  = rsp_tdata[37:33];
            seen.out_id      = rsp_tdata[69:38];
            seen.out_score   = rsp_tdata[101:70];
            seen.out_index   = rsp_tdata[121:102];
            seen.out_valid   = rsp_tuser;
            seen.last        = rsp_tlast;
            if (predicted_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOW_ERRORS)
                  $display("%0t: result with none due: %s", $realtime, report_text(seen));
            end else begin
               want = predicted_reports.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= SHOW_ERRORS) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected %s", report_text(want));
                     $display("   actual   %s", report_text(seen));
                  end
               end
            end
         end
         if (csr_wr_en) keep_count = csr_wr_data;
         if (req_tvalid && req_tready) begin
            item.id    = req_tdata[31:0];
            item.score = req_tdata[63:32];
            item.index = req_tdata[83:64];
            apply_item(req_tuser, item);
         end
      end
      mismatch_count <= mismatches;
      reports_due    <= predicted_reports.size();
   end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Top-k score keeper testbench
// Drives pushes, queries, extracts and unused actions into the keeper under
// several k settings, first a directed set of corner cases and then random
// items, with random idling on either side. The checker beside the block
// predicts and compares; this module makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module tb;
   import tksk_pkg::*;

   localparam logic [1:0]  ACT_UNUSED  = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         csr_wr_en   = 1'b0;
   logic [4:0]   csr_wr_data = '0;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [87:0]  req_tdata   = '0;
   logic [1:0]   req_tuser   = '0;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [127:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;

   int unsigned  mismatch_count;
   int unsigned  reports_due;
   int unsigned  cycle_count       = 0;
   int unsigned  sender_idle_pct   = 9;
   int unsigned  receiver_idle_pct = 72;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   top_k_score_keeper u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   score_keeper_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .reports_due    (reports_due)
   );

   // Receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // Hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // One item; returns at the accepting edge with valid still high, so the
   // next item can follow back to back
   task automatic send_item(input logic [1:0] action, input logic [ID_W-1:0] id,
                            input logic signed [SCORE_W-1:0] score,
                            input logic [NODE_W-1:0] node);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {4'b0, node, score, id};
      do @(posedge clock); while (!req_tready);
   endtask

   // Let the keeper drain, then write k
   task automatic write_keep(input logic [4:0] k);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (reports_due != 0);
      repeat (2) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly small scores so that ties and evictions are common
   function automatic logic signed [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 9))
         0:       return SCORE_MIN;
         1:       return SCORE_MAX;
         2, 3:    return $urandom();
         default: return 32'($urandom_range(0, 16)) - 32'd8;
      endcase
   endfunction

   task automatic random_item();
      int unsigned pick;
      logic [1:0]  action;
      pick = $urandom_range(0, 99);
      if (pick < 70)      action = ACT_PUSH;
      else if (pick < 88) action = ACT_QUERY;
      else if (pick < 94) action = ACT_EXTRACT;
      else                action = ACT_UNUSED;
      send_item(action, $urandom(), pick_score(), NODE_W'($urandom()));
   endtask

   initial begin
      logic [4:0] k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty store, extremes and ties at the reset k
      send_item(ACT_EXTRACT, '0, '0, '0);
      send_item(ACT_QUERY, '0, SCORE_MIN, '0);
      send_item(ACT_UNUSED, '0, '0, '0);
      send_item(ACT_PUSH, '1, SCORE_MAX, '1);
      send_item(ACT_PUSH, '0, SCORE_MIN, '0);
      send_item(ACT_PUSH, 32'h0000_0a01, 32'sd0, 20'h00a01);
      send_item(ACT_PUSH, 32'h0000_0a02, 32'sd0, 20'h00a02);
      send_item(ACT_QUERY, '0, 32'sd0, '0);
      send_item(ACT_UNUSED, '1, SCORE_MAX, '1);
      send_item(ACT_EXTRACT, '0, '0, '0);

      // k of one: equal score is refused, greater replaces
      write_keep(5'd1);
      send_item(ACT_PUSH, 32'h0000_0b01, 32'sd5, 20'h00b01);
      send_item(ACT_PUSH, 32'h0000_0b02, 32'sd5, 20'h00b02);
      send_item(ACT_PUSH, 32'h0000_0b03, 32'sd6, 20'h00b03);
      send_item(ACT_QUERY, '0, 32'sd6, '0);
      send_item(ACT_QUERY, '0, 32'sd7, '0);

      // k of zero acts as one
      write_keep(5'd0);
      send_item(ACT_PUSH, 32'h0000_0c01, 32'sd7, 20'h00c01);
      send_item(ACT_PUSH, 32'h0000_0c02, 32'sd3, 20'h00c02);

      // k above the store size saturates
      write_keep(5'd31);
      send_item(ACT_PUSH, 32'h0000_0d01, -32'sd4, 20'h00d01);
      send_item(ACT_PUSH, 32'h0000_0d02, 32'sd9, 20'h00d02);
      send_item(ACT_PUSH, 32'h0000_0d03, -32'sd4, 20'h00d03);
      send_item(ACT_PUSH, 32'h0000_0d04, 32'sd1, 20'h00d04);

      // k lowered below the fill: entries stay, only replacement remains
      write_keep(5'd2);
      send_item(ACT_PUSH, 32'h0000_0e01, -32'sd5, 20'h00e01);
      send_item(ACT_PUSH, 32'h0000_0e02, 32'sd8, 20'h00e02);
      send_item(ACT_QUERY, '0, -32'sd4, '0);
      send_item(ACT_EXTRACT, '0, '0, '0);

      // Random: three idling modes, four k settings each
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               sender_idle_pct   = 9;
               receiver_idle_pct = 72;
            end
            1: begin
               sender_idle_pct   = 72;
               receiver_idle_pct = 9;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         for (int set = 0; set < 4; set++) begin
            if (set == 0)      k = 5'd16;
            else if (set == 1) k = 5'd1;
            else               k = 5'($urandom_range(1, 16));
            write_keep(k);
            repeat (29) random_item();
         end
      end

      // Drain and verdict
      req_tvalid <= 1'b0;
      do @(posedge clock); while (reports_due != 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && reports_due == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/tksk_pkg.sv
sv/tksk_cell.sv
sv/top_k_score_keeper.sv
dv/score_keeper_checker.sv
dv/tb.sv
